>>> design/swmmm_pkg.sv
// swmmm_pkg: shared types and constants for the sliding window mean/min/max block
// no dependencies; imported by the top level and its checker

package swmmm_pkg;

  localparam int unsigned DATA_W    = 16;
  localparam int unsigned LEN_W     = 11;
  localparam int unsigned AXES      = 3;
  localparam logic [LEN_W-1:0] LEN_RESET = 11'd16;

  typedef logic signed [DATA_W-1:0] sample_t;

  // sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

endpackage

>>> design/sliding_window_mean_min_max.sv
// sliding_window_mean_min_max: top level, three-axis sliding window mean, min and max
// depends on swmmm_pkg; window store is an internal memory of MAX_WINDOW x 48 bits
//
// usage
//   input channel: in_valid_i / in_stall_o with sample_x_i, sample_y_i, sample_z_i; an item
//   is taken at a clock edge with in_valid_i high and in_stall_o low
//   output channel: out_valid_o / out_stall_i with echo, mean, low and high for each axis
//   config: cfg_we_i writes cfg_wdata_i into the window length (0 acts as 1, values above
//   MAX_WINDOW act as MAX_WINDOW); write only while the block is idle
// timing
//   each item is written to the store at once; while fewer than n samples were held
//   before it, no result comes and the next item is taken in the following cycle
//   otherwise the window is read one entry per cycle through the single memory read port,
//   then one shared restoring divider forms the three means one bit per cycle, then the
//   result goes to the output register; in_stall_o is high through the scan, the divide
//   and the wait in the done state, until the result is loaded
// reset and stall
//   reset empties the window (fill count and write slot to zero), drops any pending
//   result and sets the window length to 16; store contents are not cleared
//   a stalled result holds in the output register; the next item may be taken and worked
//   on meanwhile, and its result waits in the done state until the register frees up

module sliding_window_mean_min_max
  import swmmm_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = 1024
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration
  input  logic                    cfg_we_i,
  input  logic [LEN_W-1:0]        cfg_wdata_i,
  // input items
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [DATA_W-1:0] sample_x_i,
  input  logic signed [DATA_W-1:0] sample_y_i,
  input  logic signed [DATA_W-1:0] sample_z_i,
  // result items
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [DATA_W-1:0] echo_x_o,
  output logic signed [DATA_W-1:0] echo_y_o,
  output logic signed [DATA_W-1:0] echo_z_o,
  output logic signed [DATA_W-1:0] mean_x_o,
  output logic signed [DATA_W-1:0] mean_y_o,
  output logic signed [DATA_W-1:0] mean_z_o,
  output logic signed [DATA_W-1:0] low_x_o,
  output logic signed [DATA_W-1:0] low_y_o,
  output logic signed [DATA_W-1:0] low_z_o,
  output logic signed [DATA_W-1:0] high_x_o,
  output logic signed [DATA_W-1:0] high_y_o,
  output logic signed [DATA_W-1:0] high_z_o
);

  localparam int unsigned AW  = $clog2(MAX_WINDOW);
  localparam int unsigned CW  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned EW  = (CW > LEN_W) ? CW : LEN_W;
  localparam int unsigned SW  = DATA_W + CW;
  localparam int unsigned SCW = $clog2(SW);

  localparam logic [AW-1:0]  SLOT_LAST = AW'(MAX_WINDOW - 1);
  localparam logic [CW-1:0]  FILL_MAX  = CW'(MAX_WINDOW);
  localparam logic [EW-1:0]  LEN_MAX   = EW'(MAX_WINDOW);
  localparam logic [SCW-1:0] STEP_LAST = SCW'(SW - 1);

  // control state
  state_e            state_q, state_d;
  logic [LEN_W-1:0]  len_q;
  logic [CW-1:0]     fill_q, fill_d;
  logic [AW-1:0]     slot_q, slot_d;
  logic              out_valid_q, out_valid_d;
  logic              rvalid_q;

  // datapath state
  logic [CW-1:0]     n_q, n_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic [AXES*DATA_W-1:0] rdata_q;
  sample_t           smp_q [AXES];
  sample_t           smp_d [AXES];
  logic signed [SW-1:0] sum_q [AXES];
  logic signed [SW-1:0] sum_d [AXES];
  sample_t           lo_q [AXES];
  sample_t           lo_d [AXES];
  sample_t           hi_q [AXES];
  sample_t           hi_d [AXES];
  sample_t           mean_q [AXES];
  sample_t           mean_d [AXES];

  // shared divider
  logic [SW-1:0]     quot_q, quot_d;
  logic [CW-1:0]     rem_q, rem_d;
  logic              neg_q, neg_d;
  logic [1:0]        axis_q, axis_d;
  logic [SCW-1:0]    step_q, step_d;

  // output register
  sample_t           echo_q [AXES];
  sample_t           omean_q [AXES];
  sample_t           olow_q [AXES];
  sample_t           ohigh_q [AXES];

  // window memory
  logic [AXES*DATA_W-1:0] mem_q [MAX_WINDOW];

  logic              accept;
  logic              issue;
  logic              load_out;
  logic [EW-1:0]     len_ext;
  logic [CW-1:0]     n_eff;
  logic [1:0]        load_axis;
  logic signed [SW-1:0] sel_sum;
  logic [SW-1:0]     sel_mag;
  logic [CW:0]       trial;
  logic              ge;
  logic [CW-1:0]     rem_next;
  logic [SW-1:0]     quot_next;
  logic [DATA_W-1:0] q16;
  sample_t           mean_val;
  sample_t           rd [AXES];

  assign accept   = in_valid_i & (state_q == ST_IDLE);
  assign issue    = (state_q == ST_SCAN) && (cnt_q != n_q);
  assign load_out = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // effective window length: zero acts as one, clamp to the store depth
  assign len_ext = EW'(len_q);
  always_comb begin
    if (len_q == '0) begin
      n_eff = CW'(1);
    end else if (len_ext > LEN_MAX) begin
      n_eff = FILL_MAX;
    end else begin
      n_eff = CW'(len_ext);
    end
  end

  // memory read data split per axis
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      rd[a] = sample_t'(rdata_q[a*DATA_W +: DATA_W]);
    end
  end

  // divider operand select: axis 0 on entry, next axis within the divide phase
  assign load_axis = (state_q == ST_DIV) ? axis_q + 2'd1 : 2'd0;
  always_comb begin
    sel_sum = sum_q[0];
    if (load_axis == 2'd1) begin
      sel_sum = sum_q[1];
    end
    if (load_axis == 2'd2) begin
      sel_sum = sum_q[2];
    end
  end
  assign sel_mag = sel_sum[SW-1] ? SW'(-sel_sum) : SW'(sel_sum);

  // one restoring division step
  assign trial     = {rem_q, quot_q[SW-1]};
  assign ge        = trial >= {1'b0, n_q};
  assign rem_next  = ge ? CW'(trial - {1'b0, n_q}) : trial[CW-1:0];
  assign quot_next = {quot_q[SW-2:0], ge};
  assign q16       = quot_next[DATA_W-1:0];
  assign mean_val  = sample_t'(neg_q ? (~q16 + 1'b1) : q16);

  // sequencer
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    slot_d      = slot_q;
    n_d         = n_q;
    cnt_d       = cnt_q;
    addr_d      = addr_q;
    smp_d       = smp_q;
    sum_d       = sum_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mean_d      = mean_q;
    quot_d      = quot_q;
    rem_d       = rem_q;
    neg_d       = neg_q;
    axis_d      = axis_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          smp_d[0] = sample_x_i;
          smp_d[1] = sample_y_i;
          smp_d[2] = sample_z_i;
          slot_d   = (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
          if (fill_q != FILL_MAX) begin
            fill_d = fill_q + 1'b1;
          end
          n_d = n_eff;
          // warm-up: result only once the window was full before this sample
          if (fill_q >= n_eff) begin
            state_d = ST_SCAN;
            addr_d  = slot_q;
            cnt_d   = '0;
            sum_d[0] = '0;
            sum_d[1] = '0;
            sum_d[2] = '0;
            lo_d[0] = sample_x_i;
            lo_d[1] = sample_y_i;
            lo_d[2] = sample_z_i;
            hi_d[0] = sample_x_i;
            hi_d[1] = sample_y_i;
            hi_d[2] = sample_z_i;
          end
        end
      end
      ST_SCAN: begin
        if (issue) begin
          addr_d = (addr_q == '0) ? SLOT_LAST : addr_q - 1'b1;
          cnt_d  = cnt_q + 1'b1;
        end
        if (rvalid_q) begin
          for (int a = 0; a < AXES; a++) begin
            sum_d[a] = sum_q[a] + SW'(rd[a]);
            if (rd[a] < lo_q[a]) begin
              lo_d[a] = rd[a];
            end
            if (rd[a] > hi_q[a]) begin
              hi_d[a] = rd[a];
            end
          end
        end
        if (!issue && !rvalid_q) begin
          state_d = ST_DIV;
          axis_d  = 2'd0;
          step_d  = '0;
          quot_d  = sel_mag;
          neg_d   = sel_sum[SW-1];
          rem_d   = '0;
        end
      end
      ST_DIV: begin
        quot_d = quot_next;
        rem_d  = rem_next;
        step_d = step_q + 1'b1;
        if (step_q == STEP_LAST) begin
          for (int a = 0; a < AXES; a++) begin
            if (axis_q == 2'(a)) begin
              mean_d[a] = mean_val;
            end
          end
          if (axis_q == 2'd2) begin
            state_d = ST_DONE;
          end else begin
            axis_d = axis_q + 2'd1;
            step_d = '0;
            quot_d = sel_mag;
            neg_d  = sel_sum[SW-1];
            rem_d  = '0;
          end
        end
      end
      ST_DONE: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= LEN_RESET;
      fill_q      <= '0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
      rvalid_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
      rvalid_q    <= issue;
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    cnt_q  <= cnt_d;
    addr_q <= addr_d;
    smp_q  <= smp_d;
    sum_q  <= sum_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mean_q <= mean_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
    neg_q  <= neg_d;
    axis_q <= axis_d;
    step_q <= step_d;
    if (load_out) begin
      echo_q  <= smp_q;
      omean_q <= mean_d;
      olow_q  <= lo_q;
      ohigh_q <= hi_q;
    end
  end

  // window store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem_q[slot_q] <= {sample_z_i, sample_y_i, sample_x_i};
    end
    rdata_q <= mem_q[addr_q];
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign echo_x_o    = echo_q[0];
  assign echo_y_o    = echo_q[1];
  assign echo_z_o    = echo_q[2];
  assign mean_x_o    = omean_q[0];
  assign mean_y_o    = omean_q[1];
  assign mean_z_o    = omean_q[2];
  assign low_x_o     = olow_q[0];
  assign low_y_o     = olow_q[1];
  assign low_z_o     = olow_q[2];
  assign high_x_o    = ohigh_q[0];
  assign high_y_o    = ohigh_q[1];
  assign high_z_o    = ohigh_q[2];

endmodule

>>> design/swmmm_checker.sv
// swmmm_checker: port-level assertions for sliding_window_mean_min_max
// depends on swmmm_pkg; bound to the top level at the end of this file

module swmmm_checker
  import swmmm_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic signed [DATA_W-1:0] echo_x_o,
  input logic signed [DATA_W-1:0] echo_y_o,
  input logic signed [DATA_W-1:0] echo_z_o,
  input logic signed [DATA_W-1:0] mean_x_o,
  input logic signed [DATA_W-1:0] mean_y_o,
  input logic signed [DATA_W-1:0] mean_z_o,
  input logic signed [DATA_W-1:0] low_x_o,
  input logic signed [DATA_W-1:0] low_y_o,
  input logic signed [DATA_W-1:0] low_z_o,
  input logic signed [DATA_W-1:0] high_x_o,
  input logic signed [DATA_W-1:0] high_y_o,
  input logic signed [DATA_W-1:0] high_z_o
);

  // stalled result item stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  // stalled result item keeps its payload (checked on echo x, mean y, low z and high x)
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(echo_x_o) && $stable(mean_y_o) &&
                                   $stable(low_z_o) && $stable(high_x_o))
    else $error("stalled result item changed");

  // a new result only appears after the block was busy working on it
  a_rise_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result item without preceding work");

  // mean of a window lies between its extremes
  a_mean_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (low_x_o <= mean_x_o) && (mean_x_o <= high_x_o) &&
                    (low_y_o <= mean_y_o) && (mean_y_o <= high_y_o) &&
                    (low_z_o <= mean_z_o) && (mean_z_o <= high_z_o))
    else $error("mean outside window min/max");

  // current sample is part of its own window
  a_echo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (low_x_o <= echo_x_o) && (echo_x_o <= high_x_o) &&
                    (low_y_o <= echo_y_o) && (echo_y_o <= high_y_o) &&
                    (low_z_o <= echo_z_o) && (echo_z_o <= high_z_o))
    else $error("echoed sample outside window min/max");

endmodule

bind sliding_window_mean_min_max swmmm_checker u_swmmm_checker (.*);
